FILE: sv/nmea_rmc_field_extractor_core_macros.svh
// ----------------------------------------------------------------------------
// NMEA RMC field extractor assertion macros
// Shared property shorthands for the checker of the extractor core.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_FIELD_EXTRACTOR_CORE_MACROS_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRMC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NRMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC field extractor package
// Character codes, sentence prefix and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package nrmc_pkg;

   // Character codes seen on the byte stream
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;

   // Length of the "$GPRMC" sentence prefix
   localparam logic [2:0] PREFIX_LEN = 3'd6;

   // Character expected at each prefix position
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = CHAR_DOLLAR;
         3'd1:    c = 8'h47;   // G
         3'd2:    c = 8'h50;   // P
         3'd3:    c = 8'h52;   // R
         3'd4:    c = 8'h4D;   // M
         3'd5:    c = 8'h43;   // C
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // Commands from the controller to the datapath
   typedef struct packed {
      logic take_byte;     // process the accepted input beat
      logic slot_read;     // read the pending and record stores at the current slot
      logic slot_load;     // load the output beat and update the record
      logic slot_advance;  // output beat taken, step to the next slot
      logic line_done;     // run finished, clear the line state
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_newline;    // input byte ends the line
      logic slot_last;     // current slot is the final one of the record
   } dp_status_type;

endpackage

`default_nettype wire

FILE: sv/nrmc_if.sv
// ----------------------------------------------------------------------------
// NMEA RMC field extractor channels
// Valid/ready channels for the byte input and the record slot output.
// ----------------------------------------------------------------------------
`default_nettype none

interface nrmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_rsp_if;
   logic       valid;
   logic       ready;
   logic       matched;
   logic [1:0] field_id;
   logic [3:0] char_pos;
   logic [7:0] char_value;
   logic       run_last;

   modport source (output valid, output matched, output field_id, output char_pos,
                   output char_value, output run_last, input ready);
   modport sink   (input valid, input matched, input field_id, input char_pos,
                   input char_value, input run_last, output ready);
endinterface

`default_nettype wire

FILE: sv/nrmc_ctrl.sv
// ----------------------------------------------------------------------------
// NMEA RMC field extractor controller
// Sequences byte intake and the per-slot read, load and send of a record run.
// ----------------------------------------------------------------------------
`default_nettype none

module nrmc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output nrmc_pkg::ctrl_cmd_type      cmd,
   input  wire nrmc_pkg::dp_status_type status
);
   import nrmc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SEND
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   // Decode commands from the current state
   always_comb begin
      cmd              = '0;
      cmd.take_byte    = (state_ff == ST_IDLE) && req_valid && req_ready_ff;
      cmd.slot_read    = (state_ff == ST_READ);
      cmd.slot_load    = (state_ff == ST_LOAD);
      cmd.slot_advance = (state_ff == ST_SEND) && rsp_ready;
      cmd.line_done    = (state_ff == ST_SEND) && rsp_ready && status.slot_last;
   end

   // Hold state and the registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               req_ready_ff <= 1'b1;
               if (req_valid && req_ready_ff && status.is_newline) begin
                  req_ready_ff <= 1'b0;
                  state_ff     <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_SEND;
            end
            ST_SEND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (status.slot_last) begin
                     req_ready_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: sv/nrmc_dp.sv
// ----------------------------------------------------------------------------
// NMEA RMC field extractor datapath
// Line tokenizer, pending and record character stores, slot output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nrmc_dp #(
   parameter int LINE_MAX    = 255,
   parameter int COORD_CHARS = 15,
   parameter int HEMI_CHARS  = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire nrmc_pkg::ctrl_cmd_type  cmd,
   output nrmc_pkg::dp_status_type      status,
   input  wire logic [7:0]              rx_byte,
   output logic                         matched,
   output logic [1:0]                   field_id,
   output logic [3:0]                   char_pos,
   output logic [7:0]                   char_value,
   output logic                         run_last
);
   import nrmc_pkg::*;

   // Record layout; COORD_CHARS must be the widest field, the block does not enforce it
   localparam int SLOTS = 2 * COORD_CHARS + 2 * HEMI_CHARS;
   localparam int SAW   = $clog2(SLOTS);
   localparam int LPW   = $clog2(LINE_MAX + 1);
   localparam int CW    = $clog2(COORD_CHARS + 1);
   localparam int PW    = $clog2(COORD_CHARS);

   localparam logic [SAW-1:0] BASE_NS = SAW'(COORD_CHARS);
   localparam logic [SAW-1:0] BASE_LO = SAW'(COORD_CHARS + HEMI_CHARS);
   localparam logic [SAW-1:0] BASE_EW = SAW'(2 * COORD_CHARS + HEMI_CHARS);
   localparam logic [SAW-1:0] SLOT_END = SAW'(SLOTS - 1);
   localparam logic [LPW-1:0] LINE_END = LPW'(LINE_MAX);

   function automatic logic [SAW-1:0] field_base(input logic [1:0] f);
      logic [SAW-1:0] b;
      unique case (f)
         2'd0:    b = '0;
         2'd1:    b = BASE_NS;
         2'd2:    b = BASE_LO;
         default: b = BASE_EW;
      endcase
      return b;
   endfunction

   function automatic logic [CW-1:0] field_size(input logic [1:0] f);
      return f[0] ? CW'(HEMI_CHARS) : CW'(COORD_CHARS);
   endfunction

   function automatic logic [PW-1:0] field_last(input logic [1:0] f);
      return f[0] ? PW'(HEMI_CHARS - 1) : PW'(COORD_CHARS - 1);
   endfunction

   // Line state
   logic [LPW-1:0] line_pos_ff, line_pos_in;
   logic [2:0]     prog_ff, prog_in;
   logic           ok_ff, ok_in;
   logic [3:0]     tok_ff, tok_in;
   logic           inside_ff, inside_in;
   logic           ended_ff, ended_in;
   logic [CW-1:0]  cit_ff, cit_in;
   logic [3:0]     seen_ff, seen_in;
   logic [CW-1:0]  len_ff [4];
   logic [CW-1:0]  len_in [4];

   // Record and slot state
   logic [3:0]     rec_valid_ff, rec_valid_in;
   logic [SAW-1:0] slot_ff, slot_in;
   logic [1:0]     fld_ff, fld_in;
   logic [PW-1:0]  pos_ff, pos_in;

   // Stores and their registered read data
   logic [7:0]     pend_mem [SLOTS];
   logic [7:0]     rec_mem  [SLOTS];
   logic [7:0]     pend_rd_ff;
   logic [7:0]     rec_rd_ff;
   logic           pend_we;
   logic [SAW-1:0] pend_addr;
   logic           rec_we;
   logic [7:0]     slot_value;
   logic [PW+3:0]  pos_ext;

   // Output beat registers
   logic           matched_ff;
   logic [1:0]     field_id_ff;
   logic [3:0]     char_pos_ff;
   logic [7:0]     char_value_ff;
   logic           run_last_ff;

   assign status.is_newline = (rx_byte == CHAR_NEWLINE);
   assign status.slot_last  = (slot_ff == SLOT_END);

   // Tokenize the accepted byte, or clear the line at the end of a run
   always_comb begin
      line_pos_in = line_pos_ff;
      prog_in     = prog_ff;
      ok_in       = ok_ff;
      tok_in      = tok_ff;
      inside_in   = inside_ff;
      ended_in    = ended_ff;
      cit_in      = cit_ff;
      seen_in     = seen_ff;
      len_in      = len_ff;
      pend_we     = 1'b0;
      pend_addr   = '0;
      if (cmd.take_byte) begin
         // restart the line on a dollar sign
         if (rx_byte == CHAR_DOLLAR) begin
            line_pos_in = '0;
            prog_in     = '0;
            ok_in       = 1'b0;
            tok_in      = '0;
            inside_in   = 1'b0;
            ended_in    = 1'b0;
            cit_in      = '0;
            seen_in     = '0;
         end
         if (line_pos_in < LINE_END) begin
            if (!ended_in) begin
               if (rx_byte == CHAR_NUL) begin
                  ended_in = 1'b1;
               end else begin
                  // track the sentence prefix
                  if ((line_pos_in < LPW'(PREFIX_LEN)) && (prog_in == line_pos_in[2:0]) &&
                      (rx_byte == prefix_char(line_pos_in[2:0]))) begin
                     prog_in = prog_in + 3'd1;
                     if (prog_in == PREFIX_LEN) begin
                        ok_in = 1'b1;
                     end
                  end
                  if (rx_byte == CHAR_COMMA) begin
                     inside_in = 1'b0;
                  end else begin
                     // open a new token
                     if (!inside_in) begin
                        inside_in = 1'b1;
                        if (tok_in != 4'd15) begin
                           tok_in = tok_in + 4'd1;
                        end
                        cit_in = '0;
                        if (tok_in[3:2] == 2'b01) begin
                           seen_in[tok_in[1:0]] = 1'b1;
                           len_in[tok_in[1:0]]  = '0;
                        end
                     end
                     // store the character of a kept field
                     if ((tok_in[3:2] == 2'b01) && (cit_in < field_size(tok_in[1:0]))) begin
                        pend_we   = 1'b1;
                        pend_addr = field_base(tok_in[1:0]) + SAW'(cit_in);
                        cit_in    = cit_in + CW'(1);
                        len_in[tok_in[1:0]] = cit_in;
                     end
                  end
               end
            end
            line_pos_in = line_pos_in + LPW'(1);
         end
      end else if (cmd.line_done) begin
         line_pos_in = '0;
         prog_in     = '0;
         ok_in       = 1'b0;
         tok_in      = '0;
         inside_in   = 1'b0;
         ended_in    = 1'b0;
         cit_in      = '0;
         seen_in     = '0;
      end
   end

   // Pick the slot value: fresh field from this line, else the stored record
   always_comb begin
      if (ok_ff && seen_ff[fld_ff]) begin
         slot_value = (CW'(pos_ff) < len_ff[fld_ff]) ? pend_rd_ff : CHAR_NUL;
      end else begin
         slot_value = rec_valid_ff[fld_ff] ? rec_rd_ff : CHAR_NUL;
      end
      rec_we       = cmd.slot_load && ok_ff && seen_ff[fld_ff];
      rec_valid_in = rec_valid_ff;
      if (rec_we) begin
         rec_valid_in[fld_ff] = 1'b1;
      end
      pos_ext = {4'b0000, pos_ff};
   end

   // Step through the record slots
   always_comb begin
      slot_in = slot_ff;
      fld_in  = fld_ff;
      pos_in  = pos_ff;
      if (cmd.slot_advance) begin
         if (slot_ff == SLOT_END) begin
            slot_in = '0;
            fld_in  = '0;
            pos_in  = '0;
         end else begin
            slot_in = slot_ff + SAW'(1);
            if (pos_ff == field_last(fld_ff)) begin
               pos_in = '0;
               fld_in = fld_ff + 2'd1;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end
      end
   end

   // Hold line, record and slot control state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff  <= '0;
         prog_ff      <= '0;
         ok_ff        <= 1'b0;
         tok_ff       <= '0;
         inside_ff    <= 1'b0;
         ended_ff     <= 1'b0;
         cit_ff       <= '0;
         seen_ff      <= '0;
         rec_valid_ff <= '0;
         slot_ff      <= '0;
         fld_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         line_pos_ff  <= line_pos_in;
         prog_ff      <= prog_in;
         ok_ff        <= ok_in;
         tok_ff       <= tok_in;
         inside_ff    <= inside_in;
         ended_ff     <= ended_in;
         cit_ff       <= cit_in;
         seen_ff      <= seen_in;
         rec_valid_ff <= rec_valid_in;
         slot_ff      <= slot_in;
         fld_ff       <= fld_in;
         pos_ff       <= pos_in;
      end
   end

   // Field lengths are only read behind a seen bit
   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

   // Pending store: written by the tokenizer, read during the run
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_addr] <= rx_byte;
      end
      if (cmd.slot_read) begin
         pend_rd_ff <= pend_mem[slot_ff];
      end
   end

   // Record store: read and rewritten one slot at a time during the run
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[slot_ff] <= slot_value;
      end
      if (cmd.slot_read) begin
         rec_rd_ff <= rec_mem[slot_ff];
      end
   end

   // Load the output beat
   always_ff @(posedge clock) begin
      if (cmd.slot_load) begin
         matched_ff    <= ok_ff;
         field_id_ff   <= fld_ff;
         char_pos_ff   <= pos_ext[3:0];
         char_value_ff <= slot_value;
         run_last_ff   <= (slot_ff == SLOT_END);
      end
   end

   assign matched    = matched_ff;
   assign field_id   = field_id_ff;
   assign char_pos   = char_pos_ff;
   assign char_value = char_value_ff;
   assign run_last   = run_last_ff;

endmodule

`default_nettype wire

FILE: sv/nmea_rmc_field_extractor_core.sv
// ----------------------------------------------------------------------------
// NMEA RMC field extractor core
// Parses $GPRMC sentences from a byte stream and replays the position record.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one received character per beat (rx_byte). A '$' restarts
//   the line; a newline ends it. Tokens four to seven of a $GPRMC line
//   (latitude, N/S, longitude, E/W) overwrite the stored record.
//   rsp_if carries one beat per record slot after every newline:
//   2*COORD_CHARS + 2*HEMI_CHARS beats (32 at defaults), run_last on the
//   final one, matched set on all of them when the line carried the $GPRMC prefix.
// Timing:
//   A byte other than newline leaves req_if ready.
//   After a newline beat req_if drops ready for the run. The controller then
//   steps the slots one at a time, each through the store read, output load
//   and send states, since the store reads are registered. req_if is ready
//   again in the cycle after the final beat is taken. A stalled rsp_if holds
//   the current beat and pauses the run.
// Reset:
//   Synchronous, active high; clears the line state and the record to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_field_extractor_core #(
   parameter int LINE_MAX    = 255,
   parameter int COORD_CHARS = 15,
   parameter int HEMI_CHARS  = 1
) (
   input  wire logic  clock,
   input  wire logic  reset,
   nrmc_req_if.sink   req_if,
   nrmc_rsp_if.source rsp_if
);
   import nrmc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   // Controller
   nrmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath
   nrmc_dp #(
      .LINE_MAX    (LINE_MAX),
      .COORD_CHARS (COORD_CHARS),
      .HEMI_CHARS  (HEMI_CHARS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .rx_byte    (req_if.rx_byte),
      .matched    (rsp_if.matched),
      .field_id   (rsp_if.field_id),
      .char_pos   (rsp_if.char_pos),
      .char_value (rsp_if.char_value),
      .run_last   (rsp_if.run_last)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

endmodule

`default_nettype wire

FILE: sv/nrmc_checker.sv
// ----------------------------------------------------------------------------
// NMEA RMC field extractor checker
// Port-level properties of the extractor core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nmea_rmc_field_extractor_core_macros.svh"

module nrmc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] rx_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       matched,
   input wire logic [1:0] field_id,
   input wire logic [3:0] char_pos,
   input wire logic [7:0] char_value,
   input wire logic       run_last
);
   import nrmc_pkg::*;

   // No byte intake while a record run is showing a beat
   `NRMC_ASSERT_SAME(a_no_intake_in_run, clock, reset, rsp_valid, !req_ready, "ready during run")

   // A newline beat starts a run and closes the input
   `NRMC_ASSERT_NEXT(a_newline_closes, clock, reset, req_valid && req_ready && (rx_byte == CHAR_NEWLINE), !req_ready, "ready after newline")

   // The final slot of a run reopens the input
   `NRMC_ASSERT_NEXT(a_last_reopens, clock, reset, rsp_valid && rsp_ready && run_last, req_ready && !rsp_valid, "input not reopened")

   // A stalled beat holds
   `NRMC_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(matched) && $stable(field_id) && $stable(char_pos) && $stable(char_value) && $stable(run_last), "stalled beat changed")

endmodule

bind nmea_rmc_field_extractor_core nrmc_checker u_nrmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rx_byte    (req_if.rx_byte),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .matched    (rsp_if.matched),
   .field_id   (rsp_if.field_id),
   .char_pos   (rsp_if.char_pos),
   .char_value (rsp_if.char_value),
   .run_last   (rsp_if.run_last)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC field extractor core testbench
// Streams random and hand-picked sentence bytes into the extractor. A local
// parser tracks the line state and stored position record. It queues the
// 32-slot record replay expected after every newline, and each output beat is
// compared field by field against that queue. Both channels stall at random.
// ----------------------------------------------------------------------------

module tb_top;
   import nrmc_pkg::*;

   // Block geometry at default parameters
   localparam int unsigned LINE_LIMIT = 255;
   localparam int unsigned COORD_LEN  = 15;
   localparam int unsigned HEMI_LEN   = 1;
   localparam int unsigned SLOTS      = 2 * COORD_LEN + 2 * HEMI_LEN;
   localparam int unsigned TAG_LEN    = 6;
   localparam logic [47:0] RMC_TAG    = "$GPRMC";
   localparam int unsigned TOKEN_CAP  = 15;

   // Record field codes
   localparam logic [1:0] FIELD_LAT = 2'd0;
   localparam logic [1:0] FIELD_NS  = 2'd1;
   localparam logic [1:0] FIELD_LON = 2'd2;
   localparam logic [1:0] FIELD_EW  = 2'd3;

   // Run control
   localparam int unsigned PHASE_BYTES = 16;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned DRAIN_WAIT  = 100;
   localparam int unsigned STUCK_LIMIT = 2000;

   typedef struct packed {
      logic       matched;
      logic [1:0] field_id;
      logic [3:0] char_pos;
      logic [7:0] char_value;
      logic       run_last;
   } slot_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nrmc_req_if req_ch ();
   nrmc_rsp_if rsp_ch ();

   nmea_rmc_field_extractor_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #5 clock = ~clock;

   // Stimulus and expectation stores
   logic [7:0]    pending_bytes[$];
   slot_beat_type expected_slots[$];

   int unsigned req_idle_pct = 19;
   int unsigned rsp_idle_pct = 60;
   bit          hold_arm     = 1'b0;
   bit          hold_taken;
   int unsigned hold_left;
   int unsigned stuck_cycles;

   int unsigned bytes_queued   = 0;
   int unsigned bytes_accepted = 0;
   int unsigned slots_checked  = 0;
   int unsigned lines_ended    = 0;
   int unsigned lines_matched  = 0;
   int unsigned mismatches     = 0;

   // Parser state of the line being received
   int unsigned   line_pos;
   int unsigned   tag_progress;
   bit            tag_ok;
   int unsigned   token_no;
   bit            in_token;
   bit            content_done;
   int unsigned   token_chars;
   logic [7:0]    line_field_chars[SLOTS];
   logic [3:0]    line_fields_seen;
   logic [7:0]    record_chars[SLOTS];

   function automatic int unsigned field_width(input logic [1:0] f);
      return f[0] ? HEMI_LEN : COORD_LEN;
   endfunction

   function automatic int unsigned field_offset(input logic [1:0] f);
      case (f)
         FIELD_LAT: return 0;
         FIELD_NS:  return COORD_LEN;
         FIELD_LON: return COORD_LEN + HEMI_LEN;
         FIELD_EW:  return 2 * COORD_LEN + HEMI_LEN;
         default:   return 0;
      endcase
   endfunction

   task automatic restart_line();
      line_pos         = 0;
      tag_progress     = 0;
      tag_ok           = 1'b0;
      token_no         = 0;
      in_token         = 1'b0;
      content_done     = 1'b0;
      token_chars      = 0;
      line_fields_seen = '0;
      foreach (line_field_chars[i]) line_field_chars[i] = 8'h00;
   endtask

   // Reset image of the parser: empty line, zeroed record
   task automatic ref_clear();
      restart_line();
      foreach (record_chars[i]) record_chars[i] = 8'h00;
   endtask

   // Fold one in-window character into the line's token state
   task automatic absorb_char(input logic [7:0] b);
      logic [1:0] f;
      if (content_done) return;
      if (b == CHAR_NUL) begin
         content_done = 1'b1;
         return;
      end
      if (line_pos < TAG_LEN && tag_progress == line_pos &&
          b == RMC_TAG[47 - 8 * line_pos -: 8]) begin
         tag_progress++;
         if (tag_progress == TAG_LEN) tag_ok = 1'b1;
      end
      if (b == CHAR_COMMA) begin
         in_token = 1'b0;
         return;
      end
      if (!in_token) begin
         in_token = 1'b1;
         if (token_no < TOKEN_CAP) token_no++;
         token_chars = 0;
         if (token_no >= 4 && token_no <= 7) begin
            f = 2'(token_no - 4);
            for (int i = 0; i < field_width(f); i++)
               line_field_chars[field_offset(f) + i] = 8'h00;
            line_fields_seen[f] = 1'b1;
         end
      end
      if (token_no >= 4 && token_no <= 7) begin
         f = 2'(token_no - 4);
         if (token_chars < field_width(f)) begin
            line_field_chars[field_offset(f) + token_chars] = b;
            token_chars++;
         end
      end
   endtask

   // Advance the parser by one accepted byte; on newline queue the record replay
   task automatic parse_byte(input logic [7:0] b);
      slot_beat_type beat;
      int unsigned   n;
      if (b == CHAR_DOLLAR) restart_line();
      if (line_pos < LINE_LIMIT) begin
         absorb_char(b);
         line_pos++;
      end
      if (b != CHAR_NEWLINE) return;
      lines_ended++;
      if (tag_ok) begin
         lines_matched++;
         for (int f = 0; f < 4; f++)
            if (line_fields_seen[f])
               for (int p = 0; p < field_width(f[1:0]); p++)
                  record_chars[field_offset(f[1:0]) + p] =
                     line_field_chars[field_offset(f[1:0]) + p];
      end
      n = 0;
      for (int f = 0; f < 4; f++) begin
         for (int p = 0; p < field_width(f[1:0]); p++) begin
            beat.matched    = tag_ok;
            beat.field_id   = f[1:0];
            beat.char_pos   = p[3:0];
            beat.char_value = record_chars[field_offset(f[1:0]) + p];
            beat.run_last   = (n == SLOTS - 1);
            expected_slots.push_back(beat);
            n++;
         end
      end
      restart_line();
   endtask

   task automatic report_diff(input string name, input int unsigned want,
                              input int unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
   endtask

   // Byte driver: advance on handshake, idle at random
   always @(posedge clock) begin : byte_driver
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= 8'h00;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            parse_byte(req_ch.rx_byte);
            bytes_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= req_idle_pct) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= pending_bytes.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Slot monitor: check each beat, drive ready with random and long stalls
   always @(posedge clock) begin : slot_monitor
      slot_beat_type got;
      slot_beat_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         hold_taken   <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.matched    = rsp_ch.matched;
            got.field_id   = rsp_ch.field_id;
            got.char_pos   = rsp_ch.char_pos;
            got.char_value = rsp_ch.char_value;
            got.run_last   = rsp_ch.run_last;
            if (expected_slots.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected slot beat, expected none, actual %p", $time, got);
            end else begin
               want = expected_slots.pop_front();
               slots_checked++;
               if (got.matched !== want.matched)
                  report_diff("matched", want.matched, got.matched);
               if (got.field_id !== want.field_id)
                  report_diff("field_id", want.field_id, got.field_id);
               if (got.char_pos !== want.char_pos)
                  report_diff("char_pos", want.char_pos, got.char_pos);
               if (got.char_value !== want.char_value)
                  report_diff("char_value", want.char_value, got.char_value);
               if (got.run_last !== want.run_last)
                  report_diff("run_last", want.run_last, got.run_last);
            end
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
         end else if (hold_arm && !hold_taken) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_taken   <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: end the run if no beat moves on either channel for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d slots still expected",
                     $time, STUCK_LIMIT, expected_slots.size());
            $display("FAIL nmea_rmc_field_extractor_core");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   // Mostly coordinate-like characters, sometimes any byte but a delimiter
   function automatic logic [7:0] token_char();
      string      digits = "0123456789.NSEW";
      logic [7:0] c;
      if ($urandom_range(3, 0) != 0) begin
         c = digits[$urandom_range(14, 0)];
      end else begin
         c = 8'($urandom_range(255, 1));
         if (c == CHAR_COMMA || c == CHAR_DOLLAR || c == CHAR_NEWLINE) c = 8'h7E;
      end
      return c;
   endfunction

   initial begin
      int unsigned phase_start;
      int unsigned pick;
      int unsigned ntok;
      int unsigned tlen;
      string       tag;

      ref_clear();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 19;
               rsp_idle_pct = 60;
            end
            1: begin
               req_idle_pct = 60;
               rsp_idle_pct = 19;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase

         if (phase == 0) begin
            // Empty line replays the cleared record
            push_byte(CHAR_NEWLINE);
            // Restart mid-line, collapsed commas, 0xFF in latitude, newline as E/W
            push_text("Z$GPRMC,,1,2,");
            push_byte(8'hFF);
            push_text("3,N,4,");
            push_byte(CHAR_NEWLINE);
            // Zero byte right after the header: matched but nothing updated
            push_text("$GPRMC");
            push_byte(CHAR_NUL);
            push_text(",S");
            push_byte(CHAR_NEWLINE);
            // Stall the result side long enough to back up the input
            hold_arm = 1'b1;
         end

         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES) begin
            pick = $urandom_range(99, 0);
            if (pick < 88) begin
               // Garbage ahead of the header, dropped at the '$'
               if (pick < 8) repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255, 0)));
               if (pick < 75) begin
                  push_text("$GPRMC");
               end else begin
                  tag = "$GPRMC";
                  tag[$urandom_range(5, 1)] = 8'($urandom_range(90, 65));
                  push_text(tag);
               end
               ntok = ($urandom_range(8, 0) == 0) ? $urandom_range(16, 8) : $urandom_range(8, 3);
               for (int t = 0; t < ntok; t++) begin
                  push_byte(CHAR_COMMA);
                  if ($urandom_range(4, 0) == 0) push_byte(CHAR_COMMA);
                  tlen = (t == 2 || t == 4) ? $urandom_range(18, 1) : $urandom_range(3, 1);
                  repeat (tlen) push_byte(token_char());
                  if ($urandom_range(39, 0) == 0) push_byte(CHAR_NUL);
               end
               if ($urandom_range(3, 0) == 0) push_byte(CHAR_COMMA);
            end else begin
               repeat ($urandom_range(12, 1)) push_byte(8'($urandom_range(255, 0)));
            end
            push_byte(CHAR_NEWLINE);
         end

         // Pause the sender until every queued slot has been seen
         while (pending_bytes.size() != 0 || req_ch.valid || expected_slots.size() != 0)
            @(negedge clock);
      end

      repeat (DRAIN_WAIT) @(negedge clock);

      $display("Run covered %0d bytes over %0d lines (%0d with the RMC header),",
               bytes_accepted, lines_ended, lines_matched);
      $display("%0d record slots checked, %0d mismatches", slots_checked, mismatches);
      if (mismatches == 0 && expected_slots.size() == 0) begin
         $display("PASS nmea_rmc_field_extractor_core");
      end else begin
         $display("FAIL nmea_rmc_field_extractor_core");
      end
      $finish;
   end

endmodule

FILE: nmea_rmc_field_extractor_core.f
+incdir+sv
sv/nrmc_pkg.sv
sv/nrmc_if.sv
sv/nrmc_ctrl.sv
sv/nrmc_dp.sv
sv/nmea_rmc_field_extractor_core.sv
sv/nrmc_checker.sv
tb/tb_top.sv
